FILE: rtl/core/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

   localparam int WordWidth = 32;
   localparam int BlockWords = 16;
   localparam int DigestWords = 8;
   localparam int Rounds = 64;
   localparam int QueueDepth = 2;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      word_type   word;
      logic [1:0] kind;
   } cmd_type;

   localparam logic [1:0] CmdData = 2'd0;
   localparam logic [1:0] CmdPad = 2'd1;
   localparam logic [1:0] CmdFinish = 2'd2;

   localparam word_type PadMarker = 32'h80000000;

   function automatic word_type iv_word(input logic [2:0] idx);
      word_type v;
      case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k [Rounds];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
         32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
         32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
         32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
         32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
         32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
         32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
         32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
         32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction

   function automatic word_type ror(input word_type v, input int s);
      return (v >> s) | (v << (WordWidth - s));
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha256_message_hasher.sv
`default_nettype none
// Every sixteenth data word starts a compression, one round per cycle, and a step
// that folds it into the chaining value; words arriving meanwhile wait in the queue.
// A final word adds padding at one word per cycle, one or two compressions, then
// eight digest words at one per cycle while rsp_ready is high. Synchronous reset
// loads the initial hash value and empties the block and queue.
module sha256_message_hasher #(
   parameter int Depth = sha256_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_message_word,
   input  wire logic [2:0]  req_valid_bytes,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_final_word
);
   import sha256_pkg::*;

   cmd_type f_cmd, q_cmd;
   logic    f_valid, f_ready, q_valid, q_ready;

   sha256_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_message_word, .req_valid_bytes,
      .req_end_of_message, .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready));

   sha256_queue #(.Depth(Depth)) u_queue (
      .clock, .reset, .in_cmd(f_cmd), .in_valid(f_valid), .in_ready(f_ready),
      .out_cmd(q_cmd), .out_valid(q_valid), .out_ready(q_ready));

   sha256_back u_back (
      .clock, .reset, .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
      .rsp_valid, .rsp_ready, .rsp_digest_word, .rsp_word_index, .rsp_final_word);

endmodule
`default_nettype wire

FILE: rtl/core/sha256_front.sv
`default_nettype none
module sha256_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [31:0]         req_message_word,
   input  wire logic [2:0]          req_valid_bytes,
   input  wire logic                req_end_of_message,
   output sha256_pkg::cmd_type      cmd,
   output logic                     cmd_valid,
   input  wire logic                cmd_ready
);
   import sha256_pkg::*;

   // A final item with four bytes issues a data word and then a bare pad marker.
   logic     pend_ff, pend_in;
   logic [2:0] nb;
   word_type keep, mark;

   always_comb begin
      nb = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
      keep = (nb == 3'd0) ? '0 : (32'hffffffff << (6'd32 - {nb, 3'b000}));
      mark = (nb == 3'd4) ? '0 : (32'h00000080 << (5'd24 - {nb[1:0], 3'b000}));
      req_ready = cmd_ready && !pend_ff;
      cmd_valid = pend_ff || req_valid;
      pend_in = pend_ff;
      if (pend_ff) begin
         cmd.kind = CmdFinish;
         cmd.word = PadMarker;
         if (cmd_ready) begin
            pend_in = 1'b0;
         end
      end else if (!req_end_of_message) begin
         cmd.kind = CmdData;
         cmd.word = req_message_word;
      end else if (nb == 3'd4) begin
         cmd.kind = CmdData;
         cmd.word = req_message_word;
         if (req_valid && cmd_ready) begin
            pend_in = 1'b1;
         end
      end else begin
         cmd.kind = CmdPad;
         cmd.word = (req_message_word & keep) | mark;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/sha256_queue.sv
`default_nettype none
module sha256_queue #(
   parameter int Depth = sha256_pkg::QueueDepth
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sha256_pkg::cmd_type in_cmd,
   input  wire logic                in_valid,
   output logic                     in_ready,
   output sha256_pkg::cmd_type      out_cmd,
   output logic                     out_valid,
   input  wire logic                out_ready
);
   import sha256_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   cmd_type          mem_ff [Depth];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             push, pop;

   always_comb begin
      in_ready = cnt_ff != (AW+1)'(Depth);
      out_valid = cnt_ff != '0;
      out_cmd = mem_ff[rp_ff];
      push = in_valid && in_ready;
      pop = out_valid && out_ready;
      wp_in = push ? ((wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in = pop ? ((rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_cmd;
      end
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/sha256_back.sv
`default_nettype none
module sha256_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sha256_pkg::cmd_type cmd,
   input  wire logic                cmd_valid,
   output logic                     cmd_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [31:0]              rsp_digest_word,
   output logic [2:0]               rsp_word_index,
   output logic                     rsp_final_word
);
   import sha256_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ROUND = 5'b00010,
      S_ADD   = 5'b00100,
      S_FILL  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   word_type   w_ff [BlockWords];
   word_type   h_ff [DigestWords];
   word_type   r_ff [DigestWords];
   logic [3:0] fill_ff;
   logic [5:0] rnd_ff;
   logic [2:0] idx_ff;
   logic [63:0] len_ff;
   logic       fin_ff;
   logic       wrap_ff;
   logic       push;
   word_type   push_word;
   word_type   s0, s1, wn, t1, t2, b1, b0, ch, mj;

   always_comb begin
      s0 = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      b1 = ror(r_ff[4], 6) ^ ror(r_ff[4], 11) ^ ror(r_ff[4], 25);
      ch = (r_ff[4] & r_ff[5]) ^ (~r_ff[4] & r_ff[6]);
      t1 = r_ff[7] + b1 + ch + round_k(rnd_ff) + w_ff[0];
      b0 = ror(r_ff[0], 2) ^ ror(r_ff[0], 13) ^ ror(r_ff[0], 22);
      mj = (r_ff[0] & r_ff[1]) ^ (r_ff[0] & r_ff[2]) ^ (r_ff[1] & r_ff[2]);
      t2 = b0 + mj;
      cmd_ready = state_ff == S_IDLE;
      push = 1'b0;
      push_word = cmd.word;
      if (state_ff == S_IDLE && cmd_valid) begin
         push = 1'b1;
      end else if (state_ff == S_FILL) begin
         push = 1'b1;
         if (fill_ff == 4'd14) begin
            push_word = len_ff[63:32];
         end else if (fill_ff == 4'd15) begin
            push_word = wrap_ff ? '0 : len_ff[31:0];
         end else begin
            push_word = '0;
         end
      end
      rsp_valid = state_ff == S_OUT;
      rsp_digest_word = h_ff[idx_ff];
      rsp_word_index = idx_ff;
      rsp_final_word = idx_ff == 3'd7;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (cmd_valid) begin
            if (fill_ff == 4'd15) begin
               state_in = S_ROUND;
            end else if (cmd.kind != CmdData) begin
               state_in = S_FILL;
            end
         end
         S_FILL: if (fill_ff == 4'd15) begin
            state_in = S_ROUND;
         end
         S_ROUND: if (rnd_ff == 6'd63) begin
            state_in = S_ADD;
         end
         S_ADD: begin
            if (!fin_ff) begin
               state_in = S_IDLE;
            end else if (fill_ff != 4'd0) begin
               state_in = S_FILL;
            end else if (len_ff[0] == 1'b1) begin
               state_in = S_OUT;
            end else begin
               state_in = S_FILL;
            end
         end
         S_OUT: if (rsp_ready && idx_ff == 3'd7) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // len_ff[0] is never set by data (length is byte multiple), so it marks the length block done.
   // A marker in word fourteen leaves no room for the length, so one more block follows.
   always_ff @(posedge clock) begin
      if (push) begin
         w_ff[fill_ff] <= push_word;
      end
      if (state_ff == S_ROUND) begin
         for (int i = 0; i < BlockWords - 1; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[BlockWords-1] <= wn;
         r_ff[7] <= r_ff[6];
         r_ff[6] <= r_ff[5];
         r_ff[5] <= r_ff[4];
         r_ff[4] <= r_ff[3] + t1;
         r_ff[3] <= r_ff[2];
         r_ff[2] <= r_ff[1];
         r_ff[1] <= r_ff[0];
         r_ff[0] <= t1 + t2;
      end else begin
         for (int i = 0; i < DigestWords; i++) begin
            r_ff[i] <= h_ff[i];
         end
      end
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         rnd_ff <= '0;
         idx_ff <= '0;
         len_ff <= '0;
         fin_ff <= 1'b0;
         wrap_ff <= 1'b0;
         for (int i = 0; i < DigestWords; i++) begin
            h_ff[i] <= iv_word(3'(i));
         end
      end else begin
         state_ff <= state_in;
         if (push) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (state_ff == S_IDLE && cmd_valid) begin
            if (cmd.kind != CmdData) begin
               fin_ff <= 1'b1;
               wrap_ff <= fill_ff == 4'd14;
            end
            if (cmd.kind == CmdData) begin
               len_ff <= len_ff + 64'd32;
            end else if (cmd.kind == CmdPad) begin
               len_ff <= len_ff + {59'd0, cmd.word[7] ? 2'd3 : cmd.word[15] ? 2'd2 :
                  cmd.word[23] ? 2'd1 : 2'd0, 3'b000};
            end
         end
         if (state_ff == S_FILL && fill_ff == 4'd15) begin
            len_ff[0] <= len_ff[0];
         end
         rnd_ff <= (state_ff == S_ROUND) ? rnd_ff + 1'b1 : '0;
         if (state_ff == S_ADD) begin
            for (int i = 0; i < DigestWords; i++) begin
               h_ff[i] <= h_ff[i] + r_ff[i];
            end
         end
         if (state_ff == S_FILL && fill_ff == 4'd15) begin
            len_ff[0] <= !wrap_ff;
            wrap_ff <= 1'b0;
         end
         if (state_ff == S_OUT && rsp_ready) begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff == 3'd7) begin
               fin_ff <= 1'b0;
               len_ff <= '0;
               for (int i = 0; i < DigestWords; i++) begin
                  h_ff[i] <= iv_word(3'(i));
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: tb/sha256_hasher_checker.sv
`default_nettype none
module sha256_hasher_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [31:0] req_message_word,
   input  wire logic [2:0]  req_valid_bytes,
   input  wire logic        req_end_of_message,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [31:0] rsp_digest_word,
   input  wire logic [2:0]  rsp_word_index,
   input  wire logic        rsp_final_word,
   output int               error_count,
   output int               pending_count,
   output int               digest_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        final_word;
   } digest_entry_type;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic [31:0]      hash_state [8];
   logic [31:0]      block_words [16];
   logic [3:0]       words_held;
   logic [63:0]      message_bits;
   digest_entry_type expected_digest [$];

   function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   function automatic void compress();
      logic [31:0] w [64];
      logic [31:0] r [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = block_words[i];
      for (int i = 16; i < 64; i++) begin
         w[i] = w[i-16] + w[i-7]
              + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
              + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      for (int i = 0; i < 8; i++) r[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
            + ((r[4] & r[5]) ^ (~r[4] & r[6])) + RoundConst[i] + w[i];
         t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
            + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
         r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
         r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += r[i];
   endfunction

   function automatic void append_word(input logic [31:0] w);
      block_words[words_held] = w;
      words_held = words_held + 4'd1;
      if (words_held == 4'd0) compress();
   endfunction

   function automatic void absorb_word(input logic [31:0] w, input logic [2:0] nbytes,
                                       input logic last);
      int n;
      logic [31:0] keep;
      digest_entry_type entry;
      if (!last) begin
         append_word(w);
         message_bits += 64'd32;
         return;
      end
      n = (nbytes > 3'd4) ? 4 : int'(nbytes);
      message_bits += 64'(n * 8);
      if (n == 4) begin
         append_word(w);
         append_word(32'h80000000);
      end else begin
         keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
         append_word((w & keep) | (32'h80 << (24 - 8 * n)));
      end
      if (words_held > 4'd14) while (words_held != 4'd0) append_word(32'h0);
      while (words_held < 4'd14) append_word(32'h0);
      append_word(message_bits[63:32]);
      append_word(message_bits[31:0]);
      for (int i = 0; i < 8; i++) begin
         entry = '{hash_state[i], 3'(i), i == 7};
         expected_digest = {expected_digest, entry};
      end
      for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
      words_held = 4'd0;
      message_bits = 64'd0;
   endfunction

   always @(posedge clock) begin
      digest_entry_type exp_e;
      if (reset) begin
         for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
         words_held = 4'd0;
         message_bits = 64'd0;
         expected_digest.delete();
         error_count = 0;
         digest_count = 0;
      end else begin
         if (req_valid && req_ready)
            absorb_word(req_message_word, req_valid_bytes, req_end_of_message);
         if (rsp_valid && rsp_ready) begin
            digest_count++;
            if (expected_digest.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("Unexpected digest word %h index %0d final %0b",
                           rsp_digest_word, rsp_word_index, rsp_final_word);
            end else begin
               exp_e = expected_digest.pop_front();
               if (exp_e != {rsp_digest_word, rsp_word_index, rsp_final_word}) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("Mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                              exp_e.digest_word, exp_e.word_index, exp_e.final_word,
                              rsp_digest_word, rsp_word_index, rsp_final_word);
               end
            end
         end
      end
      pending_count = expected_digest.size();
   end
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_message_word = 32'h0;
   logic [2:0]  req_valid_bytes = 3'd0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_final_word;
   int          error_count, pending_count, digest_count;
   int          idle_cycles = 0;
   int          words_sent = 0;
   int          messages_sent = 0;
   bit          quiet_phase = 1'b0;

   always #5 clock = ~clock;

   sha256_message_hasher DUT (.*);

   sha256_hasher_checker checker_inst (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Timeout: no handshake for 5000 cycles");
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int stall;
      @(posedge clock);
      @(posedge clock);
      while (1) begin
         stall = quiet_phase ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 11) : 0);
         rsp_ready <= (stall == 0);
         repeat (stall > 0 ? stall : 1) @(posedge clock);
         if (stall > 0) rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic last);
      int gap;
      gap = quiet_phase ? 0 : ($urandom_range(0, 4) == 0 ? $urandom_range(1, 11) : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_message_word <= w;
      req_valid_bytes <= nb;
      req_end_of_message <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (last) messages_sent++;
   endtask

   task automatic send_message(input int nwords, input logic [2:0] tail_bytes,
                               input bit extreme);
      logic [31:0] w;
      for (int i = 0; i < nwords; i++) begin
         w = extreme ? ((i % 2) ? 32'hffffffff : 32'h0) : $urandom;
         send_word(w, 3'($urandom), 1'b0);
      end
      send_word(extreme ? 32'hffffffff : $urandom, tail_bytes, 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_message(0, 3'd0, 1'b1);
      send_message(0, 3'd4, 1'b1);
      send_message(0, 3'd7, 1'b1);
      send_message(1, 3'd1, 1'b0);
      send_message(2, 3'd2, 1'b0);
      send_message(2, 3'd3, 1'b1);
      send_message(13, 3'd4, 1'b0);
      wait_drained();
      send_message(14, 3'd3, 1'b0);
      send_message(15, 3'd5, 1'b1);
      while (words_sent < 150) begin
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 34) : $urandom_range(0, 6);
         send_message(n, 3'($urandom), 1'b0);
      end
      quiet_phase = 1'b1;
      while (words_sent < 210) send_message($urandom_range(0, 17), 3'($urandom), 1'b0);
      wait_drained();
      repeat (20) @(posedge clock);
      $display("Hashed %0d messages from %0d words; %0d digest words checked.",
               messages_sent, words_sent, digest_count);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
